@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define PTT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define PTT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/ptt_pkg.sv @@
`default_nettype none

package ptt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int KEY_W           = 64;
  localparam int LVL_W           = 3;

  // highest legal priority level
  localparam logic [LVL_W-1:0] TOP_LEVEL = 3'd5;

  typedef enum logic [1:0] {
    OP_NEW  = 2'd0,
    OP_LIST = 2'd1,
    OP_COMP = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // command class after front-end decode
  typedef enum logic [1:0] {
    CMD_NEW,
    CMD_LIST,
    CMD_COMP,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [LVL_W-1:0] level;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/ptt_front.sv @@
`default_nettype none

module ptt_front
  import ptt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [LVL_W-1:0] level_i,
  input  wire logic [KEY_W-1:0] task_key_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  wire logic             q_full_i
);

  logic fr_vld_q, fr_vld_d;
  cmd_t fr_cmd_q, fr_cmd_d;
  logic accept;
  logic keep;

  assign in_stall_o = fr_vld_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = fr_vld_q & ~q_full_i;
  assign cmd_o      = fr_cmd_q;

  // classify the incoming item; reserved op is dropped here
  always_comb begin
    keep           = 1'b1;
    fr_cmd_d       = fr_cmd_q;
    fr_cmd_d.level = level_i;
    fr_cmd_d.key   = task_key_i;
    fr_cmd_d.kind  = CMD_BAD;
    unique case (op_e'(op_i))
      OP_NEW:  fr_cmd_d.kind = (level_i > TOP_LEVEL) ? CMD_BAD : CMD_NEW;
      OP_LIST: fr_cmd_d.kind = (level_i > TOP_LEVEL) ? CMD_BAD : CMD_LIST;
      OP_COMP: fr_cmd_d.kind = CMD_COMP;
      OP_RSVD: keep          = 1'b0;
      default: keep          = 1'b0;
    endcase
  end

  // holding register in front of the queue
  always_comb begin
    if (accept) begin
      fr_vld_d = keep;
    end else if (push_o) begin
      fr_vld_d = 1'b0;
    end else begin
      fr_vld_d = fr_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
      fr_cmd_q <= '0;
    end else begin
      fr_vld_q <= fr_vld_d;
      if (accept && keep) begin
        fr_cmd_q <= fr_cmd_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ptt_queue.sv @@
`default_nettype none

module ptt_queue
  import ptt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      vld_o,
  output cmd_t      data_o
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wp_q, wp_d;
  logic [QAW-1:0] rp_q, rp_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QUEUE_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign data_o  = slot_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  // pointer and fill bookkeeping
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QAW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QAW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/ptt_back.sv @@
`default_nettype none

module ptt_back
  import ptt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_vld_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            status_o,
  output logic [LVL_W-1:0]      entry_level_o,
  output logic [KEY_W-1:0]      entry_key_o,
  output logic                  last_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_COMP,
    S_SHIFT,
    S_REPLY
  } state_e;

  // task table
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [LVL_W-1:0] lvl_mem [TABLE_DEPTH];

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [KEY_W-1:0] mem_wkey;
  logic [LVL_W-1:0] mem_wlvl;
  logic [KEY_W-1:0] key_rd_q;
  logic [LVL_W-1:0] lvl_rd_q;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    a_q, a_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             done_q, done_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    ri_q, ri_d;
  logic [LVL_W-1:0] rl_q, rl_d;
  logic             pend_vld_q, pend_vld_d;
  logic [LVL_W-1:0] pend_lvl_q, pend_lvl_d;
  logic [KEY_W-1:0] pend_key_q, pend_key_d;
  logic             best_vld_q, best_vld_d;
  logic [LVL_W-1:0] best_lvl_q, best_lvl_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  status_e          rep_st_q, rep_st_d;
  logic [LVL_W-1:0] rep_lvl_q, rep_lvl_d;
  logic [KEY_W-1:0] rep_key_q, rep_key_d;
  logic             out_vld_q, out_vld_d;
  status_e          out_st_q, out_st_d;
  logic [LVL_W-1:0] out_lvl_q, out_lvl_d;
  logic [KEY_W-1:0] out_key_q, out_key_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             out_load;
  logic             at_end;
  logic             match;
  logic             hold;

  assign out_free      = ~out_vld_q | ~out_stall_i;
  assign out_valid_o   = out_vld_q;
  assign status_o      = out_st_q;
  assign entry_level_o = out_lvl_q;
  assign entry_key_o   = out_key_q;
  assign last_o        = out_last_q;

  // address counter sits on the last stored task
  assign at_end = (CW'(a_q) + CW'(1)) == cnt_q;
  // list walk: read entry belongs to the level being scanned
  assign match  = rv_q & (lvl_rd_q == rl_q);
  // a new match finds an earlier match waiting and the output cannot take it
  assign hold   = match & pend_vld_q & ~out_free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    a_d        = a_q;
    lvl_d      = lvl_q;
    key_d      = key_q;
    done_d     = done_q;
    rv_d       = rv_q;
    ri_d       = ri_q;
    rl_d       = rl_q;
    pend_vld_d = pend_vld_q;
    pend_lvl_d = pend_lvl_q;
    pend_key_d = pend_key_q;
    best_vld_d = best_vld_q;
    best_lvl_d = best_lvl_q;
    best_idx_d = best_idx_q;
    rep_st_d   = rep_st_q;
    rep_lvl_d  = rep_lvl_q;
    rep_key_d  = rep_key_q;
    out_load   = 1'b0;
    out_st_d   = out_st_q;
    out_lvl_d  = out_lvl_q;
    out_key_d  = out_key_q;
    out_last_d = out_last_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wkey   = '0;
    mem_wlvl   = '0;
    mem_re     = 1'b0;
    mem_ra     = a_q;

    unique case (state_q)
      S_IDLE: begin
        rep_lvl_d = '0;
        rep_key_d = '0;
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          key_d     = cmd_i.key;
          a_d       = '0;
          done_d    = 1'b0;
          rv_d      = 1'b0;
          unique case (cmd_i.kind)
            CMD_BAD: begin
              rep_st_d = ST_BAD_LEVEL;
              state_d  = S_REPLY;
            end
            CMD_NEW: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                rep_st_d = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = cnt_q[AW-1:0];
                mem_wkey = cmd_i.key;
                mem_wlvl = cmd_i.level;
                cnt_d    = cnt_q + CW'(1);
                rep_st_d = ST_DONE;
              end
              state_d = S_REPLY;
            end
            CMD_LIST: begin
              lvl_d      = cmd_i.level;
              pend_vld_d = 1'b0;
              if (cnt_q == '0) begin
                rep_st_d = ST_EMPTY;
                state_d  = S_REPLY;
              end else begin
                state_d = S_LIST;
              end
            end
            CMD_COMP: begin
              best_vld_d = 1'b0;
              if (cnt_q == '0) begin
                rep_st_d = ST_NOT_FOUND;
                state_d  = S_REPLY;
              end else begin
                state_d = S_COMP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // one pass over the table per level, issue and compare overlapped
      S_LIST: begin
        if (!hold) begin
          if (match) begin
            if (pend_vld_q) begin
              out_load   = 1'b1;
              out_st_d   = ST_ENTRY;
              out_lvl_d  = pend_lvl_q;
              out_key_d  = pend_key_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_lvl_d = rl_q;
            pend_key_d = key_rd_q;
          end
          if (!done_q) begin
            mem_re = 1'b1;
            rv_d   = 1'b1;
            rl_d   = lvl_q;
            if (at_end) begin
              a_d = '0;
              if (lvl_q == TOP_LEVEL) begin
                done_d = 1'b1;
              end else begin
                lvl_d = lvl_q + LVL_W'(1);
              end
            end else begin
              a_d = a_q + AW'(1);
            end
          end else begin
            rv_d = 1'b0;
          end
        end
        // walk finished: the held match goes out last, or an empty result if none matched
        if (done_q && !rv_q) begin
          if (pend_vld_q) begin
            rep_st_d  = ST_ENTRY;
            rep_lvl_d = pend_lvl_q;
            rep_key_d = pend_key_q;
          end else begin
            rep_st_d = ST_EMPTY;
          end
          state_d = S_REPLY;
        end
      end

      // single pass keeping the lowest level, earliest position
      S_COMP: begin
        if (!done_q) begin
          mem_re = 1'b1;
          rv_d   = 1'b1;
          ri_d   = a_q;
          if (at_end) begin
            done_d = 1'b1;
          end else begin
            a_d = a_q + AW'(1);
          end
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q && (key_rd_q == key_q) && (!best_vld_q || (lvl_rd_q < best_lvl_q))) begin
          best_vld_d = 1'b1;
          best_lvl_d = lvl_rd_q;
          best_idx_d = ri_q;
        end
        if (done_q && !rv_q) begin
          if (!best_vld_q) begin
            rep_st_d = ST_NOT_FOUND;
            state_d  = S_REPLY;
          end else if ((CW'(best_idx_q) + CW'(1)) == cnt_q) begin
            cnt_d    = cnt_q - CW'(1);
            rep_st_d = ST_DONE;
            state_d  = S_REPLY;
          end else begin
            a_d     = best_idx_q + AW'(1);
            done_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end

      // close the gap: copy each later entry down one place
      S_SHIFT: begin
        if (!done_q) begin
          mem_re = 1'b1;
          rv_d   = 1'b1;
          ri_d   = a_q;
          if (at_end) begin
            done_d = 1'b1;
          end else begin
            a_d = a_q + AW'(1);
          end
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          mem_we   = 1'b1;
          mem_wa   = ri_q - AW'(1);
          mem_wkey = key_rd_q;
          mem_wlvl = lvl_rd_q;
        end
        if (done_q && !rv_q) begin
          cnt_d    = cnt_q - CW'(1);
          rep_st_d = ST_DONE;
          state_d  = S_REPLY;
        end
      end

      // final result of the item
      S_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_st_d   = rep_st_q;
          out_lvl_d  = rep_lvl_q;
          out_key_d  = rep_key_q;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_vld_d = out_load | (out_vld_q & out_stall_i);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      a_q        <= '0;
      lvl_q      <= '0;
      key_q      <= '0;
      done_q     <= 1'b0;
      rv_q       <= 1'b0;
      ri_q       <= '0;
      rl_q       <= '0;
      pend_vld_q <= 1'b0;
      pend_lvl_q <= '0;
      pend_key_q <= '0;
      best_vld_q <= 1'b0;
      best_lvl_q <= '0;
      best_idx_q <= '0;
      rep_st_q   <= ST_DONE;
      rep_lvl_q  <= '0;
      rep_key_q  <= '0;
      out_vld_q  <= 1'b0;
      out_st_q   <= ST_DONE;
      out_lvl_q  <= '0;
      out_key_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      a_q        <= a_d;
      lvl_q      <= lvl_d;
      key_q      <= key_d;
      done_q     <= done_d;
      rv_q       <= rv_d;
      ri_q       <= ri_d;
      rl_q       <= rl_d;
      pend_vld_q <= pend_vld_d;
      pend_lvl_q <= pend_lvl_d;
      pend_key_q <= pend_key_d;
      best_vld_q <= best_vld_d;
      best_lvl_q <= best_lvl_d;
      best_idx_q <= best_idx_d;
      rep_st_q   <= rep_st_d;
      rep_lvl_q  <= rep_lvl_d;
      rep_key_q  <= rep_key_d;
      out_vld_q  <= out_vld_d;
      out_st_q   <= out_st_d;
      out_lvl_q  <= out_lvl_d;
      out_key_q  <= out_key_d;
      out_last_q <= out_last_d;
    end
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      lvl_mem[mem_wa] <= mem_wlvl;
    end
    if (mem_re) begin
      key_rd_q <= key_mem[mem_ra];
      lvl_rd_q <= lvl_mem[mem_ra];
    end
  end

endmodule

`default_nettype wire

@@ design/priority_task_table_core.sv @@
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  op_i, level_i, task_key_i
// out      out_valid_o/out_stall_i status_o, entry_level_o, entry_key_o, last_o
//
// New task, bad level, list or complete on an empty table: answered from the reply
// state after the queue. List from level L: a pass over all stored tasks per level up
// to TOP_LEVEL, one entry per cycle via the single read port unless a stall holds it.
// Complete: one scan, then any later tasks move down one place.
// Reset clears control and the task count; the table needs no clearing pass.
// Up to two decoded items wait in the queue; an output stall can freeze the list walk.

module priority_task_table_core
  import ptt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [LVL_W-1:0] level_i,
  input  wire logic [KEY_W-1:0] task_key_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            status_o,
  output logic [LVL_W-1:0]      entry_level_o,
  output logic [KEY_W-1:0]      entry_key_o,
  output logic                  last_o
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_vld;
  cmd_t q_cmd;
  logic pop;

  // decode and hold incoming transfers
  ptt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .level_i    (level_i),
    .task_key_i (task_key_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_full_i   (q_full)
  );

  // command queue between the two halves
  ptt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .data_o (q_cmd)
  );

  // table engine and output register
  ptt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_vld_i     (q_vld),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_level_o (entry_level_o),
    .entry_key_o   (entry_key_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

@@ design/ptt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module ptt_checker
  import ptt_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_stall_i,
  input wire logic [2:0]       status_i,
  input wire logic [LVL_W-1:0] entry_level_i,
  input wire logic [KEY_W-1:0] entry_key_i,
  input wire logic             last_i
);

  // a stalled result stays offered
  `PTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)

  // only defined status codes leave the block
  `PTT_ASSERT_IMP(a_status_legal, clk_i, rst_ni, out_valid_i, status_i <= ST_EMPTY)

  // every non-list result closes its item
  `PTT_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_i && status_i != ST_ENTRY, last_i)

  // non-list results carry an empty payload
  `PTT_ASSERT_IMP(a_zero_payload, clk_i, rst_ni, out_valid_i && status_i != ST_ENTRY,
    entry_key_i == '0 && entry_level_i == '0)

  // listed tasks always hold a legal level
  `PTT_ASSERT_IMP(a_entry_level, clk_i, rst_ni, out_valid_i && status_i == ST_ENTRY,
    entry_level_i <= TOP_LEVEL)

endmodule

bind priority_task_table_core ptt_checker u_ptt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_i      (status_o),
  .entry_level_i (entry_level_o),
  .entry_key_i   (entry_key_o),
  .last_i        (last_o)
);

`default_nettype wire
